### rtl/core/hmd_pkg.sv
package hmd_pkg;

  localparam int unsigned NUM_VALUES_DEF  = 256;
  localparam int unsigned COUNT_WIDTH_DEF = 32;
  localparam int unsigned VIU_WIDTH       = 9;
  localparam logic [VIU_WIDTH-1:0] VIU_RESET = 9'd256;

  typedef struct packed {
    logic [7:0] sample_value;
    logic       last_item;
  } hmd_in_t;

  typedef struct packed {
    logic       majority_found;
    logic [7:0] majority_value;
  } hmd_out_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FLUSH,
    ST_SCAN
  } hmd_state_e;

endpackage

### rtl/core/histogram_majority_detect_unit.sv
// Streams of 8-bit samples enter one beat per cycle while busy is low; each sample below
// NumValues bumps its bin in a single-port-read, single-port-write count memory, with the
// previous write forwarded so that equal samples may follow each other in consecutive
// cycles. The beat marked as last is counted like the others and then starts a sweep over
// all NumValues bins, one bin per cycle, which both looks for a majority among the first
// values_in_use bins and writes each bin back to zero. The single result appears for
// exactly one cycle on result_valid_o, cannot be held off by the receiver, and busy stays
// high until it appears. After reset a clearing pass writes every bin to zero before the
// first sample is taken. Counters saturate at their width.
module histogram_majority_detect_unit
  import hmd_pkg::*;
#(
  parameter int unsigned NumValues  = NUM_VALUES_DEF,
  parameter int unsigned CountWidth = COUNT_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  hmd_in_t              item_i,
  output logic                 result_valid_o,
  output hmd_out_t             result_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [VIU_WIDTH-1:0] cfg_data_i
);

  localparam int unsigned AddrW = (NumValues > 1) ? $clog2(NumValues) : 1;
  localparam int unsigned CmpW  = (AddrW + 1 > VIU_WIDTH) ? AddrW + 1 : VIU_WIDTH;
  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};
  localparam logic [AddrW-1:0]      LastAddr = AddrW'(NumValues - 1);
  localparam logic [AddrW:0]        NumCnt   = (AddrW + 1)'(NumValues);

  logic [CountWidth-1:0] mem [NumValues];

  hmd_state_e state_q, state_d;

  logic [VIU_WIDTH-1:0]  viu_q;
  logic [CountWidth-1:0] total_q, total_d;
  logic [AddrW:0]        cnt_q, cnt_d;

  logic                  s1_valid_q;
  logic                  s1_bin_q;
  logic [AddrW-1:0]      s1_addr_q;

  logic                  wb_valid_q;
  logic [AddrW-1:0]      wb_addr_q;
  logic [CountWidth-1:0] wb_data_q;

  logic                  chk_valid_q;
  logic [AddrW-1:0]      chk_addr_q;
  logic                  found_q, found_d;
  logic [AddrW-1:0]      which_q, which_d;

  logic                  result_valid_q;
  hmd_out_t              result_q;

  logic [CountWidth-1:0] rd_q;
  logic                  mem_re, mem_we;
  logic [AddrW-1:0]      mem_raddr, mem_waddr;
  logic [CountWidth-1:0] mem_wdata;

  logic                  accept;
  logic                  in_range;
  logic [CountWidth-1:0] operand;
  logic [CountWidth-1:0] bumped;
  logic                  in_limit;
  logic                  hit;
  logic                  scan_issue;
  logic                  scan_done;

  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign in_range    = CmpW'(item_i.sample_value) < CmpW'(NumValues);
  assign scan_issue  = cnt_q < NumCnt;
  assign scan_done   = chk_valid_q && (chk_addr_q == LastAddr);

  assign operand = (wb_valid_q && (wb_addr_q == s1_addr_q)) ? wb_data_q : rd_q;
  assign bumped  = (operand == CountMax) ? operand : operand + 1'b1;

  assign in_limit = CmpW'(chk_addr_q) < CmpW'(viu_q);
  assign hit      = chk_valid_q && !found_q && in_limit && (rd_q > (total_q >> 1));
  assign found_d  = found_q || hit;
  assign which_d  = found_q ? which_q : chk_addr_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (cnt_q[AddrW-1:0] == LastAddr) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && item_i.last_item) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    busy      = 1'b1;
    mem_re    = 1'b0;
    mem_raddr = AddrW'(item_i.sample_value);
    mem_we    = 1'b0;
    mem_waddr = s1_addr_q;
    mem_wdata = bumped;
    cnt_d     = cnt_q;
    total_d   = total_q;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q[AddrW-1:0];
        mem_wdata = '0;
        cnt_d     = (cnt_q[AddrW-1:0] == LastAddr) ? '0 : cnt_q + 1'b1;
      end
      ST_IDLE: begin
        busy   = 1'b0;
        mem_re = accept && in_range;
        mem_we = s1_valid_q && s1_bin_q;
        cnt_d  = '0;
        if (accept) begin
          total_d = (total_q == CountMax) ? total_q : total_q + 1'b1;
        end
      end
      ST_FLUSH: begin
        mem_we = s1_valid_q && s1_bin_q;
        cnt_d  = '0;
      end
      ST_SCAN: begin
        mem_re    = scan_issue;
        mem_raddr = cnt_q[AddrW-1:0];
        mem_we    = chk_valid_q;
        mem_waddr = chk_addr_q;
        mem_wdata = '0;
        if (scan_issue) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (scan_done) begin
          total_d = '0;
        end
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      viu_q          <= VIU_RESET;
      total_q        <= '0;
      cnt_q          <= '0;
      s1_valid_q     <= 1'b0;
      wb_valid_q     <= 1'b0;
      chk_valid_q    <= 1'b0;
      found_q        <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      total_q        <= total_d;
      cnt_q          <= cnt_d;
      s1_valid_q     <= accept;
      chk_valid_q    <= (state_q == ST_SCAN) && scan_issue;
      result_valid_q <= (state_q == ST_SCAN) && scan_done;
      if (cfg_valid_i && cfg_ready_o) begin
        viu_q <= cfg_data_i;
      end
      if (mem_we) begin
        wb_valid_q <= 1'b1;
      end
      if (state_q == ST_FLUSH) begin
        found_q <= 1'b0;
      end else if (chk_valid_q) begin
        found_q <= found_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_bin_q  <= in_range;
      s1_addr_q <= AddrW'(item_i.sample_value);
    end
    if (mem_we) begin
      wb_addr_q <= mem_waddr;
      wb_data_q <= mem_wdata;
    end
    if (chk_valid_q) begin
      which_q <= which_d;
    end
    if (scan_done) begin
      result_q.majority_found <= found_d;
      result_q.majority_value <= found_d ? 8'(which_d) : 8'd0;
    end
  end

  // The check stage follows the read address, not the recorded winner.
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_SCAN) && scan_issue) begin
      chk_addr_q <= cnt_q[AddrW-1:0];
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  a_result_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(state_q) == ST_SCAN) && (state_q == ST_IDLE))
    else $error("result issued outside the end of a sweep");

  a_total_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (total_q == '0))
    else $error("item total not cleared with the result");

  a_no_value_without_majority: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.majority_found) |-> (result_o.majority_value == 8'd0))
    else $error("value reported without a majority");

  a_update_before_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> ((state_q == ST_IDLE) || (state_q == ST_FLUSH)))
    else $error("bin update overlaps a sweep");

endmodule
